// ===== hdl/keyed_token_bucket_lockout_table_macros.svh =====
// Assertion macros shared by the keyed token bucket lockout table RTL.
`ifndef KEYED_TOKEN_BUCKET_LOCKOUT_TABLE_MACROS_SVH
`define KEYED_TOKEN_BUCKET_LOCKOUT_TABLE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked property, switched off while reset is asserted.
`define KTBL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property that also holds during reset.
`define KTBL_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KTBL_ASSERT(label, clk, rst_n, prop, msg)
`define KTBL_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== hdl/ktbl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktbl_pkg
// Types, constants and codes of the keyed token bucket lockout table.
// ----------------------------------------------------------------------------
package ktbl_pkg;

    localparam int TABLE_SIZE      = 1024;
    localparam int ADDR_W          = $clog2(TABLE_SIZE);
    localparam int KEY_BYTES       = 8;
    localparam int BYTE_CNT_W      = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int FRAC_BITS       = 10;
    localparam int KEY_W           = 64;
    localparam int MS_W            = 48;
    localparam int LVL_W           = 37;
    localparam int MILLI_PER_TOKEN = 1000;
    localparam int TOKEN_UNIT      = MILLI_PER_TOKEN << FRAC_BITS;
    localparam int HASH_MUL        = 131;
    localparam int FULLM_W         = 26;
    localparam int DIV_N_W         = MS_W + FRAC_BITS;
    localparam int DIV_CNT_W       = $clog2(DIV_N_W);
    localparam int REFILL_W        = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;

    typedef logic [2:0] t_kind;
    localparam t_kind KIND_CONSUME     = 3'd0;
    localparam t_kind KIND_GATE        = 3'd1;
    localparam t_kind KIND_LOGIN_CHECK = 3'd2;
    localparam t_kind KIND_LOGIN_FAIL  = 3'd3;
    localparam t_kind KIND_LOGIN_OK    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE_BURST      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFILL_SECONDS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAILURES    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_SECONDS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_BURST      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_REFILL     = 3'd5;

    localparam logic [15:0] RST_RATE_BURST      = 16'd30;
    localparam logic [15:0] RST_REFILL_SECONDS  = 16'd1;
    localparam logic [7:0]  RST_MAX_FAILURES    = 8'd5;
    localparam logic [15:0] RST_LOCKOUT_SECONDS = 16'd900;
    localparam logic [15:0] RST_GATE_BURST      = 16'd20;
    localparam logic [15:0] RST_GATE_REFILL     = 16'd30;

    typedef struct packed {
        t_kind             kind;
        logic [KEY_W-1:0]  key;
        logic [MS_W-1:0]   now_ms;
    } t_in_item;

    typedef struct packed {
        logic allowed;
        logic slot_found;
    } t_out_item;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic              started;
        logic [LVL_W-1:0]  level;
        logic [MS_W-1:0]   last;
        logic [7:0]        fail;
        logic [MS_W-1:0]   lock;
    } t_row;

    typedef struct packed {
        logic accept;
        logic hash_step;
        logic rd;
        logic load_row;
        logic probe_next;
        logic prep;
        logic div_start;
        logic calc;
        logic write;
        logic clear;
        logic set_def;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic kind_bad;
        logic hash_last;
        logic clear_last;
        logic row_empty;
        logic row_match;
        logic probe_last;
        logic need_div;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ===== hdl/ktbl_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktbl_div
// Restoring divider, one quotient bit per cycle, for the bucket refill.
// ----------------------------------------------------------------------------
module ktbl_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ktbl_pkg::DIV_N_W-1:0]    i_num,
    input  logic [ktbl_pkg::REFILL_W-1:0]   i_den,
    output logic                            o_done,
    output logic [ktbl_pkg::DIV_N_W-1:0]    o_quo
);

    logic                             r_busy;
    logic                             r_done;
    logic [ktbl_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [ktbl_pkg::REFILL_W-1:0]    r_rem;
    logic [ktbl_pkg::REFILL_W-1:0]    r_den;
    logic [ktbl_pkg::DIV_N_W-1:0]     r_quo;
    logic [ktbl_pkg::REFILL_W:0]      w_trial;
    logic                             w_ge;

    assign w_trial = {r_rem, r_quo[ktbl_pkg::DIV_N_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == ktbl_pkg::DIV_CNT_W'(ktbl_pkg::DIV_N_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            // The remainder stays below the divisor, so it fits the divisor width.
            r_rem <= w_ge ? ktbl_pkg::REFILL_W'(w_trial - {1'b0, r_den})
                          : ktbl_pkg::REFILL_W'(w_trial);
            r_quo <= {r_quo[ktbl_pkg::DIV_N_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== hdl/ktbl_dp.sv =====
`timescale 1ns / 1ps
`include "keyed_token_bucket_lockout_table_macros.svh"
// ----------------------------------------------------------------------------
// ktbl_dp
// Datapath: configuration, hash, slot table, bucket and lockout arithmetic.
// ----------------------------------------------------------------------------
module ktbl_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ktbl_pkg::t_cmd                    i_cmd,
    output ktbl_pkg::t_sts                    o_sts,
    input  ktbl_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output ktbl_pkg::t_out_item               o_out_data,
    input  logic                              i_cfg_we,
    input  logic [ktbl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ktbl_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // Configuration registers.
    logic [15:0] r_rate_burst;
    logic [15:0] r_refill_seconds;
    logic [7:0]  r_max_failures;
    logic [15:0] r_lockout_seconds;
    logic [15:0] r_gate_burst;
    logic [15:0] r_gate_refill;

    // Request and working registers.
    ktbl_pkg::t_kind                      r_kind;
    logic [ktbl_pkg::KEY_W-1:0]           r_key;
    logic [ktbl_pkg::MS_W-1:0]            r_now;
    logic [ktbl_pkg::ADDR_W-1:0]          r_hash;
    logic [ktbl_pkg::BYTE_CNT_W-1:0]      r_byte_cnt;
    logic [ktbl_pkg::ADDR_W-1:0]          r_slot;
    logic [ktbl_pkg::ADDR_W-1:0]          r_probe;
    ktbl_pkg::t_row                       r_rd;
    ktbl_pkg::t_row                       r_row;
    logic [ktbl_pkg::FULLM_W-1:0]         r_full_milli;
    logic [ktbl_pkg::FULLM_W-1:0]         r_lock_add;
    logic [ktbl_pkg::LVL_W-1:0]           r_lvl;
    logic                                 r_skip;
    logic                                 r_allow;
    logic                                 r_found;
    logic                                 r_out_valid;
    ktbl_pkg::t_out_item                  r_out_data;

    ktbl_pkg::t_row                       r_mem [0:ktbl_pkg::TABLE_SIZE-1];

    logic                                 w_is_bucket;
    logic [15:0]                          w_burst;
    logic [15:0]                          w_refill;
    logic                                 w_zero;
    logic                                 w_later;
    logic                                 w_need_div;
    logic [ktbl_pkg::MS_W-1:0]            w_delta;
    logic [ktbl_pkg::DIV_N_W-1:0]         w_num;
    logic [ktbl_pkg::DIV_N_W-1:0]         w_quo;
    logic                                 w_div_done;
    logic [ktbl_pkg::LVL_W-1:0]           w_full;
    logic                                 w_q_big;
    logic [ktbl_pkg::LVL_W:0]             w_sum;
    logic [ktbl_pkg::LVL_W-1:0]           w_refilled;
    logic [7:0]                           w_fail_inc;
    logic [ktbl_pkg::MS_W:0]              w_lock_sum;
    logic [ktbl_pkg::MS_W-1:0]            w_lock_end;
    logic                                 w_take;
    logic                                 w_bkt_act;
    ktbl_pkg::t_row                       w_wr_row;
    logic                                 w_wr_allow;
    logic [7:0]                           w_byte;
    logic [ktbl_pkg::ADDR_W-1:0]          w_hash_next;
    logic                                 w_out_free;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_burst      <= ktbl_pkg::RST_RATE_BURST;
            r_refill_seconds  <= ktbl_pkg::RST_REFILL_SECONDS;
            r_max_failures    <= ktbl_pkg::RST_MAX_FAILURES;
            r_lockout_seconds <= ktbl_pkg::RST_LOCKOUT_SECONDS;
            r_gate_burst      <= ktbl_pkg::RST_GATE_BURST;
            r_gate_refill     <= ktbl_pkg::RST_GATE_REFILL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ktbl_pkg::CFG_RATE_BURST:      r_rate_burst      <= i_cfg_data;
                ktbl_pkg::CFG_REFILL_SECONDS:  r_refill_seconds  <= i_cfg_data;
                ktbl_pkg::CFG_MAX_FAILURES:    r_max_failures    <= i_cfg_data[7:0];
                ktbl_pkg::CFG_LOCKOUT_SECONDS: r_lockout_seconds <= i_cfg_data;
                ktbl_pkg::CFG_GATE_BURST:      r_gate_burst      <= i_cfg_data;
                ktbl_pkg::CFG_GATE_REFILL:     r_gate_refill     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hash: one key byte per step, most significant byte first.
    always_comb begin
        w_byte      = 8'(r_key >> (8 * (ktbl_pkg::KEY_BYTES - 1 - int'(r_byte_cnt))));
        w_hash_next = ktbl_pkg::ADDR_W'(32'(r_hash) * 32'(ktbl_pkg::HASH_MUL) + 32'(w_byte));
    end

    // Bucket selection and refill arithmetic.
    always_comb begin
        w_is_bucket = (r_kind == ktbl_pkg::KIND_CONSUME) || (r_kind == ktbl_pkg::KIND_GATE);
        w_burst     = (r_kind == ktbl_pkg::KIND_GATE) ? r_gate_burst : r_rate_burst;
        w_refill    = (r_kind == ktbl_pkg::KIND_GATE) ? r_gate_refill : r_refill_seconds;
        w_zero      = (w_burst == '0) || (w_refill == '0);
        w_later     = (r_now > r_row.last);
        w_need_div  = w_is_bucket && !w_zero && r_row.started && w_later;
        w_delta     = r_now - r_row.last;
        w_num       = {w_delta, {ktbl_pkg::FRAC_BITS{1'b0}}};
        w_full      = ktbl_pkg::LVL_W'(r_full_milli) << ktbl_pkg::FRAC_BITS;
        // The quotient's integer part can alone decide that the bucket simply fills up.
        w_q_big     = (w_quo[ktbl_pkg::DIV_N_W-1:ktbl_pkg::FRAC_BITS]
                       >= ktbl_pkg::MS_W'(r_full_milli));
        w_sum       = (ktbl_pkg::LVL_W+1)'(r_row.level)
                    + (ktbl_pkg::LVL_W+1)'(w_quo[ktbl_pkg::LVL_W-1:0]);
        if (w_q_big || (w_sum > (ktbl_pkg::LVL_W+1)'(w_full))) begin
            w_refilled = w_full;
        end else begin
            w_refilled = w_sum[ktbl_pkg::LVL_W-1:0];
        end
        w_fail_inc  = (r_row.fail == 8'hFF) ? r_row.fail : r_row.fail + 8'd1;
        w_lock_sum  = (ktbl_pkg::MS_W+1)'(r_now) + (ktbl_pkg::MS_W+1)'(r_lock_add);
        w_lock_end  = w_lock_sum[ktbl_pkg::MS_W] ? '1 : w_lock_sum[ktbl_pkg::MS_W-1:0];
        w_take      = (r_lvl >= ktbl_pkg::LVL_W'(ktbl_pkg::TOKEN_UNIT));
        w_bkt_act   = w_is_bucket && !r_skip;
        w_wr_row    = r_row;
        w_wr_allow  = r_allow;
        if (w_bkt_act) begin
            w_wr_allow     = w_take;
            w_wr_row.level = w_take ? r_lvl - ktbl_pkg::LVL_W'(ktbl_pkg::TOKEN_UNIT) : r_lvl;
        end
        w_out_free  = !r_out_valid || !i_out_stall;
    end

    ktbl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_refill),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Slot table: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_mem[r_slot] <= '0;
        end else if (i_cmd.write) begin
            r_mem[r_slot] <= w_wr_row;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[r_slot];
        end
    end

    // Slot pointer and probe count; the pointer also sweeps the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_probe <= '0;
        end else if (i_cmd.clear || i_cmd.probe_next) begin
            r_slot  <= r_slot + 1'b1;
            r_probe <= r_probe + 1'b1;
        end else if (i_cmd.hash_step) begin
            r_slot  <= w_hash_next;
            r_probe <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind     <= i_in_data.kind;
            r_key      <= i_in_data.key;
            r_now      <= i_in_data.now_ms;
            r_hash     <= '0;
            r_byte_cnt <= '0;
        end else if (i_cmd.hash_step) begin
            r_hash     <= w_hash_next;
            r_byte_cnt <= r_byte_cnt + 1'b1;
        end

        if (i_cmd.load_row) begin
            r_row <= r_rd;
            if (!r_rd.valid) begin
                r_row.valid <= 1'b1;
                r_row.key   <= r_key;
            end
        end else if (i_cmd.calc) begin
            r_skip  <= w_zero;
            r_allow <= 1'b1;
            unique case (r_kind)
                ktbl_pkg::KIND_CONSUME, ktbl_pkg::KIND_GATE: begin
                    if (!w_zero) begin
                        if (!r_row.started) begin
                            r_lvl         <= w_full;
                            r_row.started <= 1'b1;
                            r_row.last    <= r_now;
                        end else if (w_later) begin
                            r_lvl         <= w_refilled;
                            r_row.last    <= r_now;
                        end else begin
                            r_lvl         <= r_row.level;
                        end
                    end
                end
                ktbl_pkg::KIND_LOGIN_CHECK: begin
                    r_allow <= (r_row.lock <= r_now);
                end
                ktbl_pkg::KIND_LOGIN_FAIL: begin
                    if (r_max_failures != '0) begin
                        if (w_fail_inc >= r_max_failures) begin
                            r_row.lock <= w_lock_end;
                            r_row.fail <= '0;
                        end else begin
                            r_row.fail <= w_fail_inc;
                        end
                    end
                end
                default: begin
                    r_row.fail <= '0;
                    r_row.lock <= '0;
                end
            endcase
        end

        if (i_cmd.prep) begin
            r_full_milli <= ktbl_pkg::FULLM_W'(32'(w_burst) * 32'(ktbl_pkg::MILLI_PER_TOKEN));
            r_lock_add   <= ktbl_pkg::FULLM_W'(32'(r_lockout_seconds)
                                               * 32'(ktbl_pkg::MILLI_PER_TOKEN));
        end

        if (i_cmd.write) begin
            r_allow <= w_wr_allow;
            r_found <= 1'b1;
        end else if (i_cmd.set_def) begin
            r_allow <= 1'b1;
            r_found <= 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_data.allowed    <= r_allow;
            r_out_data.slot_found <= r_found;
        end
    end

    always_comb begin
        o_sts.kind_bad   = (r_kind > ktbl_pkg::KIND_LOGIN_OK);
        o_sts.hash_last  = (r_byte_cnt == ktbl_pkg::BYTE_CNT_W'(ktbl_pkg::KEY_BYTES - 1));
        o_sts.clear_last = (r_slot == ktbl_pkg::ADDR_W'(ktbl_pkg::TABLE_SIZE - 1));
        o_sts.row_empty  = !r_rd.valid;
        o_sts.row_match  = (r_rd.key == r_key);
        o_sts.probe_last = (r_probe == ktbl_pkg::ADDR_W'(ktbl_pkg::TABLE_SIZE - 1));
        o_sts.need_div   = w_need_div;
        o_sts.div_done   = w_div_done;
        o_sts.out_free   = w_out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `KTBL_ASSERT(a_written_row_valid, i_clk, i_rst_n, i_cmd.write |-> w_wr_row.valid, "row written without valid")
    `KTBL_ASSERT(a_written_row_key, i_clk, i_rst_n, i_cmd.write |-> (w_wr_row.key == r_key), "row written under another key")
    `KTBL_ASSERT(a_out_load_free, i_clk, i_rst_n, i_cmd.out_load |-> w_out_free, "result loaded over a waiting result")
    `KTBL_ASSERT(a_div_before_calc, i_clk, i_rst_n, (i_cmd.calc && w_need_div) |-> w_div_done, "refill used before the divide finished")

endmodule

// ===== hdl/ktbl_ctrl.sv =====
`timescale 1ns / 1ps
`include "keyed_token_bucket_lockout_table_macros.svh"
// ----------------------------------------------------------------------------
// ktbl_ctrl
// Sequencer for clearing, hashing, probing, update and result hand-off.
// ----------------------------------------------------------------------------
module ktbl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  ktbl_pkg::t_sts  i_sts,
    output ktbl_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_RD,
        S_CMP,
        S_PREP,
        S_DIV,
        S_CALC,
        S_WRITE,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_HASH;
                end
            end
            S_HASH: begin
                if (i_sts.kind_bad) begin
                    o_cmd.set_def = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.hash_step = 1'b1;
                    if (i_sts.hash_last) begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CMP;
            end
            S_CMP: begin
                if (i_sts.row_empty || i_sts.row_match) begin
                    o_cmd.load_row = 1'b1;
                    n_state        = S_PREP;
                end else if (i_sts.probe_last) begin
                    // Every slot holds another key: allow and leave the table alone.
                    o_cmd.set_def = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.probe_next = 1'b1;
                    n_state          = S_RD;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                if (i_sts.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_CALC;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    `KTBL_ASSERT_NR(a_reset_starts_clear, i_clk, (!i_rst_n) |=> (r_state == S_CLEAR), "reset did not start the clearing pass")

endmodule

// ===== hdl/keyed_token_bucket_lockout_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_token_bucket_lockout_table
// Hashed per-key table with token bucket rate limits and login lockout.
// ----------------------------------------------------------------------------
//  Channel   Handshake                    Payload
//  request   i_in_valid / o_in_stall      i_in_data  (kind, key, now_ms)
//  result    o_out_valid / i_out_stall    o_out_data (allowed, slot_found)
//  config    i_cfg_we                     i_cfg_index, i_cfg_data
//
// After reset the table is cleared one slot per cycle, all 1024 slots, with no
// request taken. A request is then accepted, hashed one key byte per step,
// probed slot by slot (read, then compare), updated and handed off; bucket
// requests with elapsed time also run the bit-serial refill divide before the
// update. One request is in work at a time; a finished result waits in the
// output register while the next request is accepted and worked on.
module keyed_token_bucket_lockout_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  ktbl_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output ktbl_pkg::t_out_item               o_out_data,
    input  logic                              i_cfg_we,
    input  logic [ktbl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ktbl_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    ktbl_pkg::t_cmd w_cmd;
    ktbl_pkg::t_sts w_sts;

    ktbl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ktbl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule
